[src/rwp_pkg.sv]
package rwp_pkg;

  // Field widths of the request and result items.
  localparam int ADDR_W = 10;
  localparam int BYTE_W = 8;

  // Command codes carried by a request.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_PACKET = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOR  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Address ranges used when a queued write is packed.
  localparam logic [ADDR_W-1:0] ADDR_SHORT_LIMIT = 10'h0FC;
  localparam logic [ADDR_W-1:0] ADDR_LONG_LO     = 10'h100;
  localparam logic [ADDR_W-1:0] ADDR_LONG_HI     = 10'h1FB;

  // Fixed packet bytes.
  localparam logic [BYTE_W-1:0] BYTE_ESC      = 8'hFE;
  localparam logic [BYTE_W-1:0] BYTE_PAD      = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_RST0     = 8'hFD;
  localparam logic [BYTE_W-1:0] BYTE_RST1     = 8'h82;
  localparam logic [BYTE_W-1:0] READ_OOR_BYTE = 8'hFF;

  // Depth of the job queue between front and back.
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] reg_addr;
    logic [BYTE_W-1:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] byte_out;
    logic [1:0]        status;
    logic              last;
  } out_item_t;

  // Operation decided by the front for each request.
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_WRITE_OOR,
    OP_READ,
    OP_READ_OOR,
    OP_FLUSH,
    OP_RESET
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] value;
  } job_t;

  // Control from the back to the front.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_FL_FETCH,
    S_FL_DECODE,
    S_FL_EMIT,
    S_RST_EMIT,
    S_PAD
  } back_state_t;

endpackage

[src/rwp_ram.sv]
module rwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rwp_front.sv]
module rwp_front #(
  parameter int SHADOW_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rwp_pkg::in_item_t  in_data,
  output logic               job_valid,
  output rwp_pkg::job_t      job,
  input  rwp_pkg::back_ctl_t ctl
);

  import rwp_pkg::*;

  job_t               slot_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr_r;
  logic [JOBQ_AW-1:0] rd_ptr_r;
  logic [JOBQ_CW-1:0] cnt_r;
  logic               push;
  logic               addr_oor;
  job_t               job_in;

  // Requests wait while the job queue is full or the shadow is being cleared.
  assign in_stall  = (cnt_r == JOBQ_CW'(JOBQ_DEPTH)) || ctl.clearing;
  assign push      = in_valid && !in_stall;
  assign job_valid = (cnt_r != '0);
  assign job       = slot_r[rd_ptr_r];

  // Classify the request into an operation.
  assign addr_oor = ({1'b0, in_data.reg_addr} >= (ADDR_W + 1)'(SHADOW_DEPTH));

  always_comb begin
    job_in.addr  = in_data.reg_addr;
    job_in.value = in_data.reg_value;
    unique case (in_data.command)
      CMD_WRITE: job_in.op = addr_oor ? OP_WRITE_OOR : OP_WRITE;
      CMD_READ:  job_in.op = addr_oor ? OP_READ_OOR : OP_READ;
      CMD_FLUSH: job_in.op = OP_FLUSH;
      CMD_RESET: job_in.op = OP_RESET;
    endcase
  end

  // Job queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= job_in;
    end
  end

  // Job queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + JOBQ_AW'(1);
      end
      if (ctl.pop) begin
        rd_ptr_r <= rd_ptr_r + JOBQ_AW'(1);
      end
      if (push && !ctl.pop) begin
        cnt_r <= cnt_r + JOBQ_CW'(1);
      end else if (!push && ctl.pop) begin
        cnt_r <= cnt_r - JOBQ_CW'(1);
      end
    end
  end

endmodule

[src/rwp_back.sv]
module rwp_back #(
  parameter int SHADOW_DEPTH = 512,
  parameter int QUEUE_DEPTH  = 256,
  parameter int PACKET_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  rwp_pkg::job_t      job,
  output rwp_pkg::back_ctl_t ctl,
  output logic               out_valid,
  input  logic               out_stall,
  output rwp_pkg::out_item_t out_data
);

  import rwp_pkg::*;

  localparam int SAW = $clog2(SHADOW_DEPTH);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int FW  = $clog2(PACKET_BYTES + 1);
  localparam int PW  = FW + 1;
  localparam int EW  = SAW + BYTE_W;

  back_state_t state_r, state_nxt;
  logic [QAW-1:0] head_r, head_nxt;
  logic [QAW-1:0] tail_r, tail_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [1:0]     sel_r, sel_nxt;
  logic [SAW-1:0] clr_r, clr_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_item_r, out_item_nxt;

  logic              out_free;
  logic              load;
  out_item_t         load_item;
  logic [QAW-1:0]    head_inc;
  logic [QAW-1:0]    tail_inc;

  logic              sh_we;
  logic [SAW-1:0]    sh_waddr;
  logic [BYTE_W-1:0] sh_wdata;
  logic              sh_re;
  logic [BYTE_W-1:0] sh_rdata;
  logic              fq_we;
  logic              fq_re;
  logic [EW-1:0]     fq_rdata;

  logic [ADDR_W-1:0] ent_addr;
  logic [BYTE_W-1:0] ent_data;
  logic              ent_short;
  logic              ent_long;
  logic [PW-1:0]     fill_ext;
  logic              fits_short;
  logic              fits_long;

  // Shadow register file.
  rwp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SHADOW_DEPTH)
  ) u_shadow (
    .clk  (clk),
    .we   (sh_we),
    .waddr(sh_waddr),
    .wdata(sh_wdata),
    .re   (sh_re),
    .raddr(job.addr[SAW-1:0]),
    .rdata(sh_rdata)
  );

  // Queue of pending register writes.
  rwp_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_wqueue (
    .clk  (clk),
    .we   (fq_we),
    .waddr(tail_r),
    .wdata({job.addr[SAW-1:0], job.value}),
    .re   (fq_re),
    .raddr(head_r),
    .rdata(fq_rdata)
  );

  // Decode of the queue entry being packed.
  assign ent_addr   = ADDR_W'(fq_rdata[EW-1:BYTE_W]);
  assign ent_data   = fq_rdata[BYTE_W-1:0];
  assign ent_short  = (ent_addr < ADDR_SHORT_LIMIT);
  assign ent_long   = (ent_addr >= ADDR_LONG_LO) && (ent_addr <= ADDR_LONG_HI);
  assign fill_ext   = {1'b0, fill_r};
  assign fits_short = (fill_ext + PW'(3)) < PW'(PACKET_BYTES);
  assign fits_long  = (fill_ext + PW'(4)) < PW'(PACKET_BYTES);

  assign head_inc = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QAW'(1);
  assign tail_inc = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QAW'(1);
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_data     = out_item_r;

  // Sequencer: next state, memory controls and result loading.
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    fill_nxt     = fill_r;
    sel_nxt      = sel_r;
    clr_nxt      = clr_r;
    sh_we        = 1'b0;
    sh_waddr     = job.addr[SAW-1:0];
    sh_wdata     = job.value;
    sh_re        = 1'b0;
    fq_we        = 1'b0;
    fq_re        = 1'b0;
    ctl.pop      = 1'b0;
    ctl.clearing = (state_r == S_CLEAR);
    load         = 1'b0;
    load_item    = '{kind: KIND_PACKET, byte_out: BYTE_PAD, status: ST_OK, last: 1'b0};

    unique case (state_r)
      S_CLEAR: begin
        sh_we    = 1'b1;
        sh_waddr = clr_r;
        sh_wdata = '0;
        clr_nxt  = clr_r + SAW'(1);
        if (clr_r == SAW'(SHADOW_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid && out_free) begin
          ctl.pop = 1'b1;
          unique case (job.op)
            OP_WRITE: begin
              load = 1'b1;
              if (count_r == CW'(QUEUE_DEPTH)) begin
                load_item = '{kind: KIND_ACK, byte_out: '0, status: ST_FULL, last: 1'b1};
              end else begin
                sh_we     = 1'b1;
                fq_we     = 1'b1;
                tail_nxt  = tail_inc;
                count_nxt = count_r + CW'(1);
                load_item = '{kind: KIND_ACK, byte_out: '0, status: ST_OK, last: 1'b1};
              end
            end
            OP_WRITE_OOR: begin
              load      = 1'b1;
              load_item = '{kind: KIND_ACK, byte_out: '0, status: ST_OOR, last: 1'b1};
            end
            OP_READ: begin
              sh_re     = 1'b1;
              state_nxt = S_READ;
            end
            OP_READ_OOR: begin
              load      = 1'b1;
              load_item = '{kind: KIND_READ, byte_out: READ_OOR_BYTE, status: ST_OK,
                            last: 1'b1};
            end
            OP_FLUSH: begin
              fill_nxt  = '0;
              state_nxt = S_FL_FETCH;
            end
            OP_RESET: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              fill_nxt  = '0;
              sel_nxt   = '0;
              state_nxt = S_RST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load      = 1'b1;
          load_item = '{kind: KIND_READ, byte_out: sh_rdata, status: ST_OK, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_FL_FETCH: begin
        if (count_r == '0) begin
          state_nxt = (fill_r == '0) ? S_IDLE : S_PAD;
        end else begin
          fq_re     = 1'b1;
          state_nxt = S_FL_DECODE;
        end
      end
      S_FL_DECODE: begin
        priority if (ent_short) begin
          sel_nxt   = 2'd1;
          state_nxt = fits_short ? S_FL_EMIT : S_PAD;
        end else if (ent_long) begin
          sel_nxt   = 2'd0;
          state_nxt = fits_long ? S_FL_EMIT : S_PAD;
        end else begin
          // Addresses outside both ranges leave the queue without a byte.
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
          state_nxt = S_FL_FETCH;
        end
      end
      S_FL_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          fill_nxt = fill_r + FW'(1);
          unique case (sel_r)
            2'd0:    load_item.byte_out = BYTE_ESC;
            2'd1:    load_item.byte_out = ent_addr[BYTE_W-1:0];
            default: load_item.byte_out = ent_data;
          endcase
          if (sel_r == 2'd2) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
            state_nxt = S_FL_FETCH;
          end else begin
            sel_nxt = sel_r + 2'd1;
          end
        end
      end
      S_RST_EMIT: begin
        if (out_free) begin
          load               = 1'b1;
          fill_nxt           = fill_r + FW'(1);
          load_item.byte_out = (sel_r == 2'd0) ? BYTE_RST0 : BYTE_RST1;
          if (sel_r == 2'd0) begin
            sel_nxt = 2'd1;
          end else begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (out_free) begin
          load           = 1'b1;
          fill_nxt       = fill_r + FW'(1);
          load_item.last = (fill_r == FW'(PACKET_BYTES - 1));
          if (load_item.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = load_item;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      sel_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      sel_r       <= sel_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // A job is taken only when one is waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> job_valid)
    else $error("job popped from an empty job queue");

  // A new result never overwrites one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_item_r == $past(out_item_r)))
    else $error("stalled result was overwritten");

  // The write queue never holds more than its depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("write queue count out of range");

  // Padding always has at least one byte left to send.
  a_pad_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAD) |-> (fill_r < FW'(PACKET_BYTES)))
    else $error("packet overfilled");

endmodule

[src/register_write_packetizer.sv]
// Register write packetizer. Requests carry one of four commands: a register write
// within the shadow range updates the shadow register file and queues the write unless
// the queue is full (one acknowledge result), a read returns the shadow byte, a flush
// packs the queued writes that fit into one packet of PACKET_BYTES bytes padded with
// 0xFF, and a queue reset empties the queue and sends the packet FD 82 padded with 0xFF.
// A two-entry job queue sits between the request classifier and the sequencer, so up to
// two requests are taken while a packet streams out. The sequencer handles one job at a
// time: a read goes through a registered shadow read, and a flush takes the job, then for
// each queued entry it examines does a write-queue memory read and then a decode, emits
// the packet bytes and pads once the queue runs empty. After reset the shadow register
// file is cleared one entry per cycle, while in_stall is high.
module register_write_packetizer #(
  parameter int SHADOW_DEPTH = 512,
  parameter int QUEUE_DEPTH  = 256,
  parameter int PACKET_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rwp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rwp_pkg::out_item_t out_data
);

  import rwp_pkg::*;

  logic      job_valid;
  job_t      job;
  back_ctl_t ctl;

  // Request classifier and job queue.
  rwp_front #(
    .SHADOW_DEPTH(SHADOW_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .job_valid(job_valid),
    .job      (job),
    .ctl      (ctl)
  );

  // Shadow, write queue and packet sequencer.
  rwp_back #(
    .SHADOW_DEPTH(SHADOW_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(job_valid),
    .job      (job),
    .ctl      (ctl),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
